### hw/rtl/lfs_pkg.sv
package lfs_pkg;

  // Field widths of the request and result items
  localparam int CHAR_W = 8;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int REG_W  = 11;
  localparam int ADDR_W = 2;

  // Largest side value, sides saturate here
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_NUM_ROWS      = 2'd0;
  localparam logic [ADDR_W-1:0] REG_NUM_COLS      = 2'd1;
  localparam logic [ADDR_W-1:0] REG_OBSTACLE_CHAR = 2'd2;

  // Reset values of the configuration registers
  localparam logic [REG_W-1:0]  NUM_ROWS_RST = 11'd1;
  localparam logic [REG_W-1:0]  NUM_COLS_RST = 11'd1;
  localparam logic [CHAR_W-1:0] OBSTACLE_RST = 8'd111;

  // Per-cell flags handed from the scan stage to the update stage
  typedef struct packed {
    logic obstacle;   // cell holds the obstacle character
    logic edge_cell;  // first row or first column
    logic row_end;    // last cell of its row
    logic map_end;    // last cell of the map
  } cell_ctl_t;

endpackage

### hw/rtl/lfs_row_mem.sv
module lfs_row_mem import lfs_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [SIZE_W-1:0]    rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [SIZE_W-1:0]    wr_data
);

  // Sides of the previous row, one entry per column
  logic [SIZE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/lfs_scan.sv
module lfs_scan import lfs_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  logic              clk,
  input  logic              rst,
  // configuration writes
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata,
  // request accepted this cycle
  input  logic              accept,
  input  logic [CHAR_W-1:0] cell_char,
  // position and flags of the current cell
  output logic [CW-1:0]     col,
  output logic [RW-1:0]     row,
  output cell_ctl_t         ctl
);

  logic [REG_W-1:0]  num_rows;
  logic [REG_W-1:0]  num_cols;
  logic [CHAR_W-1:0] obstacle_char;
  logic [CW-1:0]     col_index;
  logic [RW-1:0]     row_index;
  logic [CW:0]       cols_bound;
  logic [RW:0]       rows_bound;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows      <= NUM_ROWS_RST;
      num_cols      <= NUM_COLS_RST;
      obstacle_char <= OBSTACLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NUM_ROWS:      num_rows      <= cfg_wdata;
        REG_NUM_COLS:      num_cols      <= cfg_wdata;
        REG_OBSTACLE_CHAR: obstacle_char <= cfg_wdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize acts as the maximum
  always_comb begin
    if (num_cols == '0) begin
      cols_bound = (CW+1)'(1);
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      cols_bound = (CW+1)'(MAX_COLS);
    end else begin
      cols_bound = (CW+1)'(num_cols);
    end
    if (num_rows == '0) begin
      rows_bound = (RW+1)'(1);
    end else if (32'(num_rows) > 32'(MAX_ROWS)) begin
      rows_bound = (RW+1)'(MAX_ROWS);
    end else begin
      rows_bound = (RW+1)'(num_rows);
    end
  end

  // Flags of the current cell
  assign col_inc       = {1'b0, col_index} + (CW+1)'(1);
  assign row_inc       = {1'b0, row_index} + (RW+1)'(1);
  assign col           = col_index;
  assign row           = row_index;
  assign ctl.obstacle  = (cell_char == obstacle_char);
  assign ctl.edge_cell = (col_index == '0) || (row_index == '0);
  assign ctl.row_end   = (col_inc >= cols_bound);
  assign ctl.map_end   = ctl.row_end && (row_inc >= rows_bound);

  // Scan position, advanced on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
    end else if (accept) begin
      if (ctl.row_end) begin
        col_index <= '0;
        row_index <= ctl.map_end ? '0 : row_inc[RW-1:0];
      end else begin
        col_index <= col_inc[CW-1:0];
      end
    end
  end

endmodule

### hw/rtl/lfs_update.sv
module lfs_update import lfs_pkg::*; #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  logic              clk,
  input  logic              rst,
  // cell entering the pipeline
  input  logic              accept,
  input  logic [CW-1:0]     acc_col,
  input  logic [RW-1:0]     acc_row,
  input  cell_ctl_t         acc_ctl,
  output logic              ready,
  // row store
  input  logic [SIZE_W-1:0] mem_q,
  output logic              wr_en,
  output logic [CW-1:0]     wr_addr,
  output logic [SIZE_W-1:0] wr_data,
  // result
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SIZE_W-1:0] out_size,
  output logic [POS_W-1:0]  out_row,
  output logic [POS_W-1:0]  out_col
);

  logic              s1_valid;
  logic [CW-1:0]     s1_col;
  logic [RW-1:0]     s1_row;
  cell_ctl_t         s1_ctl;
  logic              s1_fwd;
  logic [SIZE_W-1:0] s1_fwd_side;
  logic              s1_fire;
  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diag_size;
  logic [SIZE_W-1:0] best_size;
  logic [RW-1:0]     best_row;
  logic [CW-1:0]     best_col;
  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] min3;
  logic [SIZE_W-1:0] side;
  logic              bigger;

  // Up value, forwarded when the store write to that column is in flight
  assign up = s1_fwd ? s1_fwd_side : mem_q;

  // Side of the square ending at this cell
  always_comb begin
    min3 = up;
    if (left_size < min3) min3 = left_size;
    if (diag_size < min3) min3 = diag_size;
    if (s1_ctl.obstacle) begin
      side = '0;
    end else if (s1_ctl.edge_cell) begin
      side = SIZE_W'(1);
    end else if (min3 == SIZE_MAX) begin
      side = SIZE_MAX;
    end else begin
      side = min3 + SIZE_W'(1);
    end
  end

  assign bigger  = side > best_size;
  // Map end waits while an earlier result is held and not taken this cycle
  assign s1_fire = s1_valid && !(s1_ctl.map_end && out_valid && !out_ready);
  assign ready   = !(s1_valid && s1_ctl.map_end && out_valid && !out_ready);

  assign wr_en   = s1_fire;
  assign wr_addr = s1_col;
  assign wr_data = side;

  // Pipeline register in front of the update
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= acc_col;
      s1_row      <= acc_row;
      s1_ctl      <= acc_ctl;
      s1_fwd      <= s1_fire && (s1_col == acc_col);
      s1_fwd_side <= side;
    end
  end

  // Neighbor sides and best square so far
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      best_size <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (s1_fire) begin
      left_size <= side;
      diag_size <= up;
      if (s1_ctl.map_end) begin
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else if (bigger) begin
        best_size <= side;
        best_row  <= s1_row;
        best_col  <= s1_col;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_ctl.map_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctl.map_end) begin
      out_size <= bigger ? side : best_size;
      out_row  <= bigger ? POS_W'(s1_row) : POS_W'(best_row);
      out_col  <= bigger ? POS_W'(s1_col) : POS_W'(best_col);
    end
  end

endmodule

### hw/rtl/largest_free_square_search_core.sv
// Channel   Dir  Request fields (tdata from bit 0)
// s_axis    in   cell_char[7:0]
// m_axis    out  square_size[10:0], bottom_row[20:11], right_col[30:21], zero[31]
// cfg       in   index 0 num_rows, 1 num_cols, 2 obstacle_char
//
// One cell per cycle: the row store is read when a cell is accepted and
// written as the cell leaves the pipeline register; a write and read of
// the same column are forwarded. At a map end, the last cell waits only
// while the previous result is held and m_axis_tready is low. Reset is
// synchronous; the row store needs no clearing since row 0 writes every
// column before it is read. The result is registered from the last cell.
module largest_free_square_search_core import lfs_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata,
  // cell requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // cell_char
  // results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata    // square_size, bottom_row, right_col
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic              accept;
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  cell_ctl_t         ctl;
  logic [SIZE_W-1:0] mem_q;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [SIZE_W-1:0] wr_data;
  logic [SIZE_W-1:0] square_size;
  logic [POS_W-1:0]  bottom_row;
  logic [POS_W-1:0]  right_col;

  assign accept = s_axis_tvalid && s_axis_tready;

  lfs_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cell_char (s_axis_tdata),
    .col       (col),
    .row       (row),
    .ctl       (ctl)
  );

  lfs_row_mem #(
    .DEPTH     (MAX_COLS),
    .ADDR_BITS (CW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (mem_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lfs_update #(
    .CW (CW),
    .RW (RW)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .acc_col   (col),
    .acc_row   (row),
    .acc_ctl   (ctl),
    .ready     (s_axis_tready),
    .mem_q     (mem_q),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_size  (square_size),
    .out_row   (bottom_row),
    .out_col   (right_col)
  );

  assign m_axis_tdata = {1'b0, right_col, bottom_row, square_size};

endmodule
